// ===== rtl/hc_pkg.sv =====
// Shared types, constants and mod-26 helpers for the 2x2 Hill cipher block.
package hc_pkg;

    localparam logic [4:0]  Alpha      = 5'd26;
    localparam logic [10:0] AlphaSq    = 11'd676;
    localparam logic [4:0]  PadIndex   = 5'd23;
    localparam logic [6:0]  AsciiA     = 7'd65;
    localparam logic [22:0] Mod26Recip = 23'd2521;

    localparam logic [4:0] KeyReset00 = 5'd9;
    localparam logic [4:0] KeyReset01 = 5'd4;
    localparam logic [4:0] KeyReset10 = 5'd5;
    localparam logic [4:0] KeyReset11 = 5'd7;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 5;

    localparam logic [CfgIdxW-1:0] CfgKey00   = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgKey01   = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgKey10   = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgKey11   = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgDecrypt = 3'd4;

    localparam logic [2:0] SettleCycles = 3'd5;

    typedef struct packed {
        logic [4:0] p0;
        logic [4:0] p1;
        logic       last;
    } t_pair;

    typedef struct packed {
        logic [4:0] m00;
        logic [4:0] m01;
        logic [4:0] m10;
        logic [4:0] m11;
        logic       bad;
    } t_mat;

    typedef struct packed {
        logic [4:0] r0;
        logic [4:0] r1;
        logic       last;
        logic       bad;
    } t_res;

    // x mod 26 for x < 2048, reciprocal multiply then one correction-free subtract
    function automatic logic [4:0] mod26(input logic [10:0] x);
        logic [22:0] prod;
        logic [6:0]  q;
        logic [10:0] r;
        prod = 23'(x) * Mod26Recip;
        q    = prod[22:16];
        r    = x - (11'(q) * 11'd26);
        return r[4:0];
    endfunction

    function automatic logic [4:0] red26(input logic [4:0] k);
        return (k >= Alpha) ? (k - Alpha) : k;
    endfunction

    // multiplicative inverse mod 26, zero when none exists
    function automatic logic [4:0] inv26(input logic [4:0] v);
        logic [4:0] r;
        case (v)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/hill_cipher_2x2_mod26_top.sv =====
// Top level of the streaming 2x2 Hill cipher over the 26-letter alphabet.
//
// Input channel: i_valid / o_stall carry one text byte and an end flag per
// transaction. Non-letters are dropped, lowercase folds to uppercase, letters
// are paired; a pair yields two output letters, an odd letter at the end flag
// is padded with X.
// Output channel: o_valid / i_stall carry one letter per transaction, with
// o_last_letter on the final letter of a text and o_key_bad when decrypting
// with a non-invertible key (letter then reads A).
// Configuration: i_cfg_valid / o_cfg_ready write key entries (index 0..3) and
// the decrypt flag (index 4); o_cfg_ready is always high. Write only while idle.
// The first letter of a pair passes the pair, product-sum, reduction and
// output registers; the second follows it. Throughput: one byte per cycle
// while o_stall is low, bounded by the output, which sends a pair's letters
// in turn. After reset and after every configuration write the input stalls
// while the key pipeline derives the (inverse) matrix.
// A stalled output holds its letter; the pipeline fills behind it, then
// o_stall rises until the receiver takes letters again.
module hill_cipher_2x2_mod26_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_text_byte,
    input  logic                          i_end_of_text,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [6:0]                    o_letter_out,
    output logic                          o_last_letter,
    output logic                          o_key_bad,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hc_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [hc_pkg::CfgDataW-1:0]   i_cfg_data
);

    logic          busy;
    logic          mix_ready;
    logic          pair_valid;
    hc_pkg::t_pair pair;
    hc_pkg::t_mat  mat;
    logic          res_valid;
    hc_pkg::t_res  res;
    logic          ser_ready;

    hc_keymat u_keymat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_busy      (busy),
        .o_mat       (mat)
    );

    hc_clean u_clean (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_busy        (busy),
        .i_mix_ready   (mix_ready),
        .o_stall       (o_stall),
        .o_pair_valid  (pair_valid),
        .o_pair        (pair)
    );

    hc_mix u_mix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pair_valid (pair_valid),
        .i_pair       (pair),
        .i_mat        (mat),
        .i_ser_ready  (ser_ready),
        .o_ready      (mix_ready),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    hc_ser u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res_valid   (res_valid),
        .i_res         (res),
        .i_stall       (i_stall),
        .o_ready       (ser_ready),
        .o_valid       (o_valid),
        .o_letter_out  (o_letter_out),
        .o_last_letter (o_last_letter),
        .o_key_bad     (o_key_bad)
    );

endmodule

// ===== rtl/hc_clean.sv =====
// Text cleaning and letter pairing, with the registered pair stage.
module hc_clean (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_text_byte,
    input  logic              i_end_of_text,
    input  logic              i_busy,
    input  logic              i_mix_ready,
    output logic              o_stall,
    output logic              o_pair_valid,
    output hc_pkg::t_pair     o_pair
);

    logic          r_held;
    logic [4:0]    r_held_letter;
    logic [4:0]    n_held_letter;
    logic          r_wait;
    logic          n_wait;
    logic          r_pv;
    hc_pkg::t_pair r_pair;

    logic          ready;
    logic          accept;
    logic          is_letter;
    logic [4:0]    idx;
    logic          emit;
    hc_pkg::t_pair pair;

    assign ready   = !r_pv || i_mix_ready;
    assign o_stall = !ready || i_busy;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        is_letter = i_text_byte inside {[8'd65:8'd90], [8'd97:8'd122]};
        idx       = i_text_byte[4:0] - 5'd1;
        n_wait        = r_wait;
        n_held_letter = r_held_letter;
        emit          = 1'b0;
        pair          = '0;
        if (is_letter && n_wait) begin
            emit      = 1'b1;
            pair.p0   = n_held_letter;
            pair.p1   = idx;
            pair.last = i_end_of_text;
            n_wait    = 1'b0;
        end else if (is_letter) begin
            n_held_letter = idx;
            n_wait        = 1'b1;
        end
        if (i_end_of_text && n_wait) begin
            emit      = 1'b1;
            pair.p0   = n_held_letter;
            pair.p1   = hc_pkg::PadIndex;
            pair.last = 1'b1;
            n_wait    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait        <= 1'b0;
            r_held_letter <= '0;
            r_pv          <= 1'b0;
        end else begin
            if (accept) begin
                r_wait        <= n_wait;
                r_held_letter <= n_held_letter;
            end
            if (accept && emit) begin
                r_pv <= 1'b1;
            end else if (i_mix_ready) begin
                r_pv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_pair <= pair;
        end
    end

    assign r_held       = r_wait;
    assign o_pair_valid = r_pv;
    assign o_pair       = r_pair;

    // a pair not yet taken downstream stays put
    a_pair_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv && !i_mix_ready) |=> (r_pv && $stable(r_pair)))
        else $error("pair stage changed while stalled");

    // an accepted end of text always clears the held letter
    a_pad_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_text) |=> !r_held)
        else $error("letter still held after end of text");

endmodule

// ===== rtl/hc_keymat.sv =====
// Key registers, configuration port and the pipelined key matrix / inverse derivation.
module hc_keymat (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [hc_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [hc_pkg::CfgDataW-1:0]   i_cfg_data,
    output logic                          o_cfg_ready,
    output logic                          o_busy,
    output hc_pkg::t_mat                  o_mat
);

    logic [4:0]   r_k00;
    logic [4:0]   r_k01;
    logic [4:0]   r_k10;
    logic [4:0]   r_k11;
    logic         r_dec;
    logic [2:0]   r_settle;

    logic [4:0]   r_a;
    logic [4:0]   r_b;
    logic [4:0]   r_c;
    logic [4:0]   r_d;
    logic [10:0]  r_det_raw;
    logic [4:0]   r_det;
    logic [4:0]   r_di;
    logic [9:0]   r_p00;
    logic [9:0]   r_p01;
    logic [9:0]   r_p10;
    logic [9:0]   r_p11;
    hc_pkg::t_mat r_mat;

    logic [9:0]   ad;
    logic [9:0]   bc;
    logic [4:0]   di;
    logic [4:0]   nb;
    logic [4:0]   nc;
    hc_pkg::t_mat n_mat;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_settle != 3'd0);
    assign o_mat       = r_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k00    <= hc_pkg::KeyReset00;
            r_k01    <= hc_pkg::KeyReset01;
            r_k10    <= hc_pkg::KeyReset10;
            r_k11    <= hc_pkg::KeyReset11;
            r_dec    <= 1'b0;
            r_settle <= hc_pkg::SettleCycles;
        end else if (i_cfg_valid) begin
            r_settle <= hc_pkg::SettleCycles;
            case (i_cfg_index)
                hc_pkg::CfgKey00:   r_k00 <= i_cfg_data;
                hc_pkg::CfgKey01:   r_k01 <= i_cfg_data;
                hc_pkg::CfgKey10:   r_k10 <= i_cfg_data;
                hc_pkg::CfgKey11:   r_k11 <= i_cfg_data;
                hc_pkg::CfgDecrypt: r_dec <= i_cfg_data[0];
                default: ;
            endcase
        end else if (r_settle != 3'd0) begin
            r_settle <= r_settle - 3'd1;
        end
    end

    always_comb begin
        ad = 10'(r_a) * 10'(r_d);
        bc = 10'(r_b) * 10'(r_c);
        di = hc_pkg::inv26(r_det);
        nb = (r_b == 5'd0) ? 5'd0 : (hc_pkg::Alpha - r_b);
        nc = (r_c == 5'd0) ? 5'd0 : (hc_pkg::Alpha - r_c);
        if (r_dec) begin
            n_mat.m00 = hc_pkg::mod26({1'b0, r_p00});
            n_mat.m01 = hc_pkg::mod26({1'b0, r_p01});
            n_mat.m10 = hc_pkg::mod26({1'b0, r_p10});
            n_mat.m11 = hc_pkg::mod26({1'b0, r_p11});
            n_mat.bad = (r_di == 5'd0);
        end else begin
            n_mat.m00 = r_a;
            n_mat.m01 = r_b;
            n_mat.m10 = r_c;
            n_mat.m11 = r_d;
            n_mat.bad = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a       <= hc_pkg::red26(r_k00);
        r_b       <= hc_pkg::red26(r_k01);
        r_c       <= hc_pkg::red26(r_k10);
        r_d       <= hc_pkg::red26(r_k11);
        r_det_raw <= {1'b0, ad} + hc_pkg::AlphaSq - {1'b0, bc};
        r_det     <= hc_pkg::mod26(r_det_raw);
        r_di      <= di;
        r_p00     <= 10'(di) * 10'(r_d);
        r_p01     <= 10'(di) * 10'(nb);
        r_p10     <= 10'(di) * 10'(nc);
        r_p11     <= 10'(di) * 10'(r_a);
        r_mat     <= n_mat;
    end

    // a configuration write always restarts the settling window
    a_settle_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_settle == hc_pkg::SettleCycles))
        else $error("settle counter not reloaded on write");

endmodule

// ===== rtl/hc_mix.sv =====
// Matrix times pair: product-sum stage, then mod-26 reduction stage.
module hc_mix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pair_valid,
    input  hc_pkg::t_pair i_pair,
    input  hc_pkg::t_mat  i_mat,
    input  logic          i_ser_ready,
    output logic          o_ready,
    output logic          o_res_valid,
    output hc_pkg::t_res  o_res
);

    logic         r_va;
    logic [10:0]  r_sum0;
    logic [10:0]  r_sum1;
    logic         r_last_a;
    logic         r_bad_a;
    logic         r_vb;
    hc_pkg::t_res r_res;

    logic         rdy_a;
    logic         rdy_b;
    logic [9:0]   pr00;
    logic [9:0]   pr01;
    logic [9:0]   pr10;
    logic [9:0]   pr11;
    hc_pkg::t_res n_res;

    assign rdy_b       = !r_vb || i_ser_ready;
    assign rdy_a       = !r_va || rdy_b;
    assign o_ready     = rdy_a;
    assign o_res_valid = r_vb;
    assign o_res       = r_res;

    always_comb begin
        pr00 = 10'(i_mat.m00) * 10'(i_pair.p0);
        pr01 = 10'(i_mat.m01) * 10'(i_pair.p1);
        pr10 = 10'(i_mat.m10) * 10'(i_pair.p0);
        pr11 = 10'(i_mat.m11) * 10'(i_pair.p1);
        n_res.r0   = r_bad_a ? 5'd0 : hc_pkg::mod26(r_sum0);
        n_res.r1   = r_bad_a ? 5'd0 : hc_pkg::mod26(r_sum1);
        n_res.last = r_last_a;
        n_res.bad  = r_bad_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_pair_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_pair_valid) begin
            r_sum0   <= {1'b0, pr00} + {1'b0, pr01};
            r_sum1   <= {1'b0, pr10} + {1'b0, pr11};
            r_last_a <= i_pair.last;
            r_bad_a  <= i_mat.bad;
        end
        if (rdy_b && r_va) begin
            r_res <= n_res;
        end
    end

    // a bad key always reduces to the letter A
    a_bad_is_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vb && r_res.bad) |-> (r_res.r0 == 5'd0 && r_res.r1 == 5'd0))
        else $error("bad key result not A");

endmodule

// ===== rtl/hc_ser.sv =====
// Output register: holds one result pair and sends its two letters in order.
module hc_ser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_res_valid,
    input  hc_pkg::t_res  i_res,
    input  logic          i_stall,
    output logic          o_ready,
    output logic          o_valid,
    output logic [6:0]    o_letter_out,
    output logic          o_last_letter,
    output logic          o_key_bad
);

    logic         r_full;
    logic         r_sel;
    hc_pkg::t_res r_res;

    logic         take;
    logic         load;

    assign take          = r_full && !i_stall;
    assign o_ready       = !r_full || (take && r_sel);
    assign load          = o_ready && i_res_valid;
    assign o_valid       = r_full;
    assign o_letter_out  = hc_pkg::AsciiA + {2'b00, (r_sel ? r_res.r1 : r_res.r0)};
    assign o_last_letter = r_sel && r_res.last;
    assign o_key_bad     = r_res.bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_sel  <= 1'b0;
        end else if (load) begin
            r_full <= 1'b1;
            r_sel  <= 1'b0;
        end else if (take && !r_sel) begin
            r_sel <= 1'b1;
        end else if (take) begin
            r_full <= 1'b0;
            r_sel  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_res;
        end
    end

    // the second letter of a pair always follows the first
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !r_sel) |=> (r_full && r_sel))
        else $error("second letter of pair lost");

endmodule
